[rtl/core/sbol_pkg.sv]
// Shared types and constants for the segment/box overlap length pipeline.
package sbol_pkg;

  localparam int Axes     = 3;
  localparam int CoordW   = 32;               // signed Q16.16 coordinate
  localparam int HalfW    = 31;               // unsigned Q15.16 half size
  localparam int NumW     = CoordW + 2;       // slab numerator, signed
  localparam int DenW     = CoordW;           // |end - start|, unsigned
  localparam int ProdW    = NumW + DenW + 1;  // numerator x denominator, signed
  localparam int QBits    = 30;               // fraction bits of clamped t
  localparam int QuoW     = QBits + 1;        // t in [0,1] needs one integer bit
  localparam int SqW      = 2 * DenW + 2;     // sum of three squares
  localparam int RootW    = SqW / 2;          // floor sqrt of the sum
  localparam int LenW     = 32;               // result length, Q16.16
  localparam int FrontLat = 5;                // clipping front end stages
  localparam int DiffDly  = RootW - QuoW;     // align quotients with root

  typedef struct packed {
    logic signed [CoordW-1:0] box_center_x;
    logic signed [CoordW-1:0] box_center_y;
    logic signed [CoordW-1:0] box_center_z;
    logic        [HalfW-1:0]  box_half_x;
    logic        [HalfW-1:0]  box_half_y;
    logic        [HalfW-1:0]  box_half_z;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] start_z;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic signed [CoordW-1:0] end_z;
  } sbol_in_t;

  typedef struct packed {
    logic            hit;
    logic [LenW-1:0] inside_length;
  } sbol_out_t;

  // Front end result: clamped entry/exit parameters and squared length
  typedef struct packed {
    logic            hit;
    logic [DenW-1:0] un;
    logic [DenW-1:0] ud;
    logic [DenW-1:0] vn;
    logic [DenW-1:0] vd;
    logic [SqW-1:0]  sumsq;
  } sbol_clip_t;

endpackage

[rtl/core/sbol_clip.sv]
// Slab clipping front end: entry/exit parameters, hit test, squared length.
module sbol_clip (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid_in,
  input  sbol_pkg::sbol_in_t  item,
  output logic                valid_out,
  output sbol_pkg::sbol_clip_t clip
);

  localparam int N  = sbol_pkg::NumW;
  localparam int D  = sbol_pkg::DenW;
  localparam int P  = sbol_pkg::ProdW;
  localparam int A  = sbol_pkg::Axes;
  localparam int CW = sbol_pkg::CoordW;
  localparam int HW = sbol_pkg::HalfW;

  logic [sbol_pkg::FrontLat-1:0] vld;

  // per-axis views of the input transaction
  logic signed [CW-1:0] cen [A];
  logic        [HW-1:0] half [A];
  logic signed [CW-1:0] sp [A];
  logic signed [CW-1:0] ep [A];

  assign cen[0] = item.box_center_x;
  assign cen[1] = item.box_center_y;
  assign cen[2] = item.box_center_z;
  assign half[0] = item.box_half_x;
  assign half[1] = item.box_half_y;
  assign half[2] = item.box_half_z;
  assign sp[0] = item.start_x;
  assign sp[1] = item.start_y;
  assign sp[2] = item.start_z;
  assign ep[0] = item.end_x;
  assign ep[1] = item.end_y;
  assign ep[2] = item.end_z;

  // stage A: slab numerators and denominators
  logic signed [N-1:0] lwn_next [A];
  logic signed [N-1:0] upn_next [A];
  logic        [D-1:0] den_next [A];
  logic        [A-1:0] axv_next;
  logic        [A-1:0] axm_next;

  always_comb begin
    logic signed [N-1:0] lo, hi, s34, d34, ad34;
    for (int k = 0; k < A; k++) begin
      lo   = N'(cen[k]) - $signed({{(N-HW){1'b0}}, half[k]});
      hi   = N'(cen[k]) + $signed({{(N-HW){1'b0}}, half[k]});
      s34  = N'(sp[k]);
      d34  = N'(ep[k]) - s34;
      ad34 = d34[N-1] ? -d34 : d34;
      den_next[k] = ad34[D-1:0];
      axv_next[k] = (d34 != '0);
      axm_next[k] = (d34 == '0) && ((s34 < lo) || (s34 > hi));
      if (!d34[N-1]) begin
        lwn_next[k] = lo - s34;
        upn_next[k] = hi - s34;
      end else begin
        lwn_next[k] = s34 - hi;
        upn_next[k] = s34 - lo;
      end
    end
  end

  logic signed [N-1:0] lwn_a [A];
  logic signed [N-1:0] upn_a [A];
  logic        [D-1:0] den_a [A];
  logic        [A-1:0] axv_a;
  logic                miss_a;

  always_ff @(posedge clk) begin
    lwn_a  <= lwn_next;
    upn_a  <= upn_next;
    den_a  <= den_next;
    axv_a  <= axv_next;
    miss_a <= |axm_next;
  end

  // stage B: cross products for ratio compares, squared deltas
  logic signed [P-1:0] pl_next [A][A];
  logic signed [P-1:0] pu_next [A][A];
  logic      [2*D-1:0] sq_next [A];

  always_comb begin
    for (int i = 0; i < A; i++) begin
      sq_next[i] = den_a[i] * den_a[i];
      for (int j = 0; j < A; j++) begin
        pl_next[i][j] = lwn_a[i] * $signed({1'b0, den_a[j]});
        pu_next[i][j] = upn_a[i] * $signed({1'b0, den_a[j]});
      end
    end
  end

  logic signed [P-1:0] pl_b [A][A];
  logic signed [P-1:0] pu_b [A][A];
  logic      [2*D-1:0] sq_b [A];
  logic signed [N-1:0] lwn_b [A];
  logic signed [N-1:0] upn_b [A];
  logic        [D-1:0] den_b [A];
  logic        [A-1:0] axv_b;
  logic                miss_b;

  always_ff @(posedge clk) begin
    pl_b   <= pl_next;
    pu_b   <= pu_next;
    sq_b   <= sq_next;
    lwn_b  <= lwn_a;
    upn_b  <= upn_a;
    den_b  <= den_a;
    axv_b  <= axv_a;
    miss_b <= miss_a;
  end

  // stage C: pick latest entry and earliest exit (first axis wins ties)
  logic signed [N-1:0]     entn_next, extn_next;
  logic        [D-1:0]     entd_next, extd_next;
  logic [sbol_pkg::SqW-1:0] sum_next;

  always_comb begin
    logic sel_e, sel_x;
    entn_next = '0;
    entd_next = '0;
    extn_next = '0;
    extd_next = '0;
    for (int i = 0; i < A; i++) begin
      sel_e = axv_b[i];
      sel_x = axv_b[i];
      for (int j = 0; j < A; j++) begin
        if (j < i) begin
          sel_e = sel_e & (!axv_b[j] | (pl_b[i][j] >  pl_b[j][i]));
          sel_x = sel_x & (!axv_b[j] | (pu_b[i][j] <  pu_b[j][i]));
        end else if (j > i) begin
          sel_e = sel_e & (!axv_b[j] | (pl_b[i][j] >= pl_b[j][i]));
          sel_x = sel_x & (!axv_b[j] | (pu_b[i][j] <= pu_b[j][i]));
        end
      end
      entn_next = entn_next | (sel_e ? lwn_b[i] : '0);
      entd_next = entd_next | (sel_e ? den_b[i] : '0);
      extn_next = extn_next | (sel_x ? upn_b[i] : '0);
      extd_next = extd_next | (sel_x ? den_b[i] : '0);
    end
    // no bounding axis: keep a harmless unit denominator
    if (axv_b == '0) begin
      entd_next = D'(1);
      extd_next = D'(1);
    end
    sum_next = sbol_pkg::SqW'(sq_b[0]) + sbol_pkg::SqW'(sq_b[1])
             + sbol_pkg::SqW'(sq_b[2]);
  end

  logic signed [N-1:0]      entn_c, extn_c;
  logic        [D-1:0]      entd_c, extd_c;
  logic                     have_c, miss_c;
  logic [sbol_pkg::SqW-1:0] sum_c;

  always_ff @(posedge clk) begin
    entn_c <= entn_next;
    entd_c <= entd_next;
    extn_c <= extn_next;
    extd_c <= extd_next;
    have_c <= |axv_b;
    miss_c <= miss_b;
    sum_c  <= sum_next;
  end

  // stage D: entry/exit order products, clamp to the segment
  logic signed [P-1:0] ce_next, cx_next;
  logic                ok_next;
  logic        [D-1:0] un_next, ud_next, vn_next, vd_next;

  always_comb begin
    logic in_ent, in_ext;
    ce_next = entn_c * $signed({1'b0, extd_c});
    cx_next = extn_c * $signed({1'b0, entd_c});
    in_ent  = !entn_c[N-1] && (entn_c <= $signed({2'b00, entd_c}));
    in_ext  = !extn_c[N-1] && (extn_c <= $signed({2'b00, extd_c}));
    ok_next = have_c && !miss_c && (in_ent || in_ext);
    if (entn_c[N-1]) begin
      un_next = '0;
      ud_next = D'(1);
    end else begin
      un_next = entn_c[D-1:0];
      ud_next = entd_c;
    end
    if (extn_c > $signed({2'b00, extd_c})) begin
      vn_next = D'(1);
      vd_next = D'(1);
    end else begin
      vn_next = extn_c[D-1:0];
      vd_next = extd_c;
    end
  end

  logic signed [P-1:0]      ce_d, cx_d;
  logic                     ok_d;
  logic        [D-1:0]      un_d, ud_d, vn_d, vd_d;
  logic [sbol_pkg::SqW-1:0] sum_d;

  always_ff @(posedge clk) begin
    ce_d  <= ce_next;
    cx_d  <= cx_next;
    ok_d  <= ok_next;
    un_d  <= un_next;
    ud_d  <= ud_next;
    vn_d  <= vn_next;
    vd_d  <= vd_next;
    sum_d <= sum_d_in();
  end

  function automatic logic [sbol_pkg::SqW-1:0] sum_d_in();
    return sum_c;
  endfunction

  // stage E: empty interval check, register front end result
  always_ff @(posedge clk) begin
    clip.hit   <= ok_d && !(ce_d > cx_d);
    clip.un    <= un_d;
    clip.ud    <= ud_d;
    clip.vn    <= vn_d;
    clip.vd    <= vd_d;
    clip.sumsq <= sum_d;
  end

  // advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[sbol_pkg::FrontLat-2:0], valid_in};
    end
  end

  assign valid_out = vld[sbol_pkg::FrontLat-1];

endmodule

[rtl/core/sbol_div.sv]
// Pipelined restoring divider: floor(num * 2^QBits / den) for num <= den.
module sbol_div (
  input  logic                         clk,
  input  logic [sbol_pkg::DenW-1:0]    num,
  input  logic [sbol_pkg::DenW-1:0]    den,
  output logic [sbol_pkg::QuoW-1:0]    quo
);

  localparam int D = sbol_pkg::DenW;
  localparam int Q = sbol_pkg::QuoW;

  logic [D:0]   rem_q [Q];
  logic [D-1:0] den_q [Q];
  logic [Q-1:0] quo_q [Q];

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < Q; k++) begin : g_stage
    logic [D:0]   rin, rsub;
    logic [D-1:0] din;
    logic [Q-1:0] qin;
    logic         ge;

    if (k == 0) begin : g_first
      assign rin = {1'b0, num};
      assign din = den;
      assign qin = '0;
    end else begin : g_rest
      assign rin = rem_q[k-1];
      assign din = den_q[k-1];
      assign qin = quo_q[k-1];
    end

    assign ge   = (rin >= {1'b0, din});
    assign rsub = ge ? (rin - {1'b0, din}) : rin;

    always_ff @(posedge clk) begin
      rem_q[k] <= {rsub[D-1:0], 1'b0};
      den_q[k] <= din;
      quo_q[k] <= qin | (Q'(ge) << (Q - 1 - k));
    end
  end

  assign quo = quo_q[Q-1];

endmodule

[rtl/core/sbol_sqrt.sv]
// Pipelined digit-by-digit integer square root, one root bit per stage.
module sbol_sqrt (
  input  logic                          clk,
  input  logic [sbol_pkg::SqW-1:0]      rad,
  output logic [sbol_pkg::RootW-1:0]    root
);

  localparam int S = sbol_pkg::SqW;
  localparam int R = sbol_pkg::RootW;
  localparam int W = S + 2;

  logic [W-1:0] rem_q  [R];
  logic [R-1:0] root_q [R];

  for (genvar k = 0; k < R; k++) begin : g_stage
    localparam int B = R - 1 - k;
    logic [W-1:0] rin, trial;
    logic [R-1:0] qin;
    logic         ge;

    if (k == 0) begin : g_first
      assign rin = W'(rad);
      assign qin = '0;
    end else begin : g_rest
      assign rin = rem_q[k-1];
      assign qin = root_q[k-1];
    end

    // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
    assign trial = (W'(qin) << (B + 1)) | (W'(1) << (2 * B));
    assign ge    = (rin >= trial);

    always_ff @(posedge clk) begin
      rem_q[k]  <= ge ? (rin - trial) : rin;
      root_q[k] <= qin | (R'(ge) << B);
    end
  end

  assign root = root_q[R-1];

endmodule

[rtl/core/segment_box_overlap_length.sv]
// Segment / axis-aligned box overlap length, fully pipelined top level.
//
// One transaction is taken every clock cycle: start may be high on every
// cycle and busy stays low. Each transaction gives exactly one result,
// shown for one cycle with done high; results leave in the order the
// transactions came in, and the receiver cannot stall them. The pipeline
// is 5 stages of slab clipping, 33 stages of the square root unit (one
// root bit per stage, the two parameter dividers run beside it), and 2
// stages of the final scaling multiply. On a miss hit is 0 and
// inside_length is 0; a segment lying wholly inside the box is a miss.
module segment_box_overlap_length (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  sbol_pkg::sbol_in_t   item,
  output logic                 done,
  output sbol_pkg::sbol_out_t  result
);

  localparam int R  = sbol_pkg::RootW;
  localparam int Q  = sbol_pkg::QuoW;
  localparam int DL = sbol_pkg::DiffDly;
  localparam int LW = sbol_pkg::LenW;

  logic                  clip_vld;
  sbol_pkg::sbol_clip_t  clip;
  logic [Q-1:0]          qu, qv;
  logic [R-1:0]          seg;

  assign busy = 1'b0;

  sbol_clip u_clip (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (start),
    .item      (item),
    .valid_out (clip_vld),
    .clip      (clip)
  );

  sbol_div u_div_u (
    .clk (clk),
    .num (clip.un),
    .den (clip.ud),
    .quo (qu)
  );

  sbol_div u_div_v (
    .clk (clk),
    .num (clip.vn),
    .den (clip.vd),
    .quo (qv)
  );

  sbol_sqrt u_sqrt (
    .clk  (clk),
    .rad  (clip.sumsq),
    .root (seg)
  );

  // carry valid and hit alongside the root unit
  logic [R-1:0] vld_d;
  logic [R-1:0] hit_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d <= '0;
    end else begin
      vld_d <= {vld_d[R-2:0], clip_vld};
    end
  end

  always_ff @(posedge clk) begin
    hit_d <= {hit_d[R-2:0], clip.hit};
  end

  // hold the parameter span until the root is ready
  logic [Q-1:0] diff_d [DL];

  always_ff @(posedge clk) begin
    diff_d[0] <= qv - qu;
    for (int i = 1; i < DL; i++) begin
      diff_d[i] <= diff_d[i-1];
    end
  end

  // scale stage 1: split the root into a 32-bit and a high part
  logic [LW+Q-1:0] p0;
  logic [Q-1:0]    p1;
  logic            vld_m, hit_m;

  always_ff @(posedge clk) begin
    p0    <= seg[LW-1:0] * diff_d[DL-1];
    p1    <= seg[R-1] ? diff_d[DL-1] : '0;
    hit_m <= hit_d[R-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_m <= 1'b0;
      done  <= 1'b0;
    end else begin
      vld_m <= vld_d[R-1];
      done  <= vld_m;
    end
  end

  // scale stage 2: sum partial products, drop fraction bits, saturate, zero on a miss
  logic [LW+Q+1:0] prod;
  logic [LW+Q+1:0] len;

  always_comb begin
    prod = (LW+Q+2)'(p0) + ((LW+Q+2)'(p1) << LW);
    len  = prod >> sbol_pkg::QBits;
  end

  always_ff @(posedge clk) begin
    result.hit <= hit_m;
    if (!hit_m) begin
      result.inside_length <= '0;
    end else if (len[LW+Q+1:LW] != '0) begin
      result.inside_length <= '1;
    end else begin
      result.inside_length <= len[LW-1:0];
    end
  end

endmodule
